// ===== rtl/vdc_pkg.sv =====
// Types and constants shared by the vector distance and cosine similarity block.
`default_nettype none
package vdc_pkg;

  localparam int ELEM_WIDTH  = 16;
  localparam int ELEM_FRAC   = ELEM_WIDTH - 4;
  localparam int MAG_W       = ELEM_WIDTH;
  localparam int ACC_WIDTH   = 48;
  localparam int DIST_WIDTH  = 32;
  localparam int EUC_SHIFT   = 40 - 2 * ELEM_WIDTH;
  localparam int COS_SHIFT   = 14;
  localparam int SQRT_STEPS  = 32;
  localparam int DIV_STEPS   = 17;
  localparam int CNT_W       = $clog2(SQRT_STEPS);
  localparam int COS_ONE     = 65536;

  typedef struct packed {
    logic signed [ELEM_WIDTH-1:0] elem_a;
    logic signed [ELEM_WIDTH-1:0] elem_b;
    logic                         last_elem;
  } in_item_t;

  typedef struct packed {
    logic signed [DIST_WIDTH-1:0] distance;
    logic                         zero_norm;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_DD,
    ST_MUL_AA,
    ST_MUL_BB,
    ST_MUL_AB,
    ST_ACC_AB,
    ST_START,
    ST_SQRT_E,
    ST_SQRT_A,
    ST_SQRT_B,
    ST_MUL_D,
    ST_DIV_CHK,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/vector_distance_or_cosine.sv =====
// Top level of the streaming Euclidean distance / cosine similarity engine.
//
// Usage: element pairs (elem_a, elem_b, signed Q3.12) arrive on the in_ channel with a
// valid/ready handshake; the pair with last_elem set closes the vectors. One result
// (distance, signed Q15.16, and zero_norm) leaves on the out_ channel per vector pair.
// cfg_we writes metric_mode: 0 for Euclidean distance, 1 for cosine similarity.
// Each pair is transferred and then keeps the engine busy, taking no new pair, while
// the single 32x32 multiplier is used four times (squared difference, both
// squares, cross product) and the last product is accumulated. After the last pair
// has been accumulated the result takes one 32-step square root for Euclidean
// distance; in cosine mode it goes straight to the output register when a norm is zero,
// ends at the range check when that already caps the cosine at one, and otherwise
// takes two 32-step square roots, one multiply, a range check and a 17-step
// restoring divide, all on shared units.
// The result sits in an output register, so a stalled receiver blocks the engine
// only when a second result is finished before the first transfer completes; new
// pairs are taken meanwhile. Synchronous active-low reset clears the accumulators,
// the mode register, the sequencer and the output valid.
`default_nettype none
module vector_distance_or_cosine (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire vdc_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output vdc_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic               cfg_wdata
);
  import vdc_pkg::*;

  // Saturating unsigned accumulate.
  function automatic logic [ACC_WIDTH-1:0] sat_uadd(input logic [ACC_WIDTH-1:0] acc,
                                                    input logic [ACC_WIDTH-1:0] p);
    logic [ACC_WIDTH:0] s;
    s = {1'b0, acc} + {1'b0, p};
    return s[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : s[ACC_WIDTH-1:0];
  endfunction

  state_t state_r, state_nxt;

  // Control state.
  logic                  mode_r;
  logic                  out_valid_r;
  out_item_t             out_data_r;
  logic [ACC_WIDTH-1:0]  sq_acc_r, na_acc_r, nb_acc_r;
  logic signed [ACC_WIDTH-1:0] dot_acc_r;

  // Per-pair operands.
  logic [MAG_W-1:0]      a_mag_r, b_mag_r, d_mag_r;
  logic                  neg_r, last_r;

  // Shared multiplier.
  logic [31:0]           mul_a, mul_b;
  logic [63:0]           mul_p, prod_r;

  // Shared square-root unit (two radicand bits per step).
  logic [63:0]           sq_val_r;
  logic [31:0]           sq_root_r;
  logic [33:0]           sq_rem_r;
  logic [35:0]           sq_rem_sh, sq_trial, sq_diff;
  logic                  sq_ge;
  logic [31:0]           sq_root_nxt;
  logic [33:0]           sq_rem_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic [31:0]           ra_r, rb_r;

  // Restoring divider for |dot| * 2^30 / (ra * rb).
  logic [61:0]           dv_rem_r, dv_rem_nxt;
  logic [DIV_STEPS-1:0]  dv_q_r, dv_q_nxt;
  logic [62:0]           dv_rsh, dv_den, dv_sub, dv_num_chk;
  logic                  dv_ge;
  logic [ACC_WIDTH-1:0]  dot_mag;
  logic [DIST_WIDTH-1:0] cos_q, cos_signed;

  // Result holding register.
  logic [DIST_WIDTH-1:0] res_r;
  logic                  res_zf_r;

  // Accumulate helpers.
  logic [ACC_WIDTH:0]    dot_sum, pm_ext;
  logic signed [ACC_WIDTH-1:0] dot_nxt;

  // Input pair decode.
  logic [MAG_W:0]        diff;
  logic [MAG_W-1:0]      d_mag_in, a_mag_in, b_mag_in;

  logic sq_done, dv_done, norm_zero, fin_load;

  // Input decode: magnitudes and the sign of the cross product.
  always_comb begin
    diff     = {in_data.elem_a[MAG_W-1], in_data.elem_a}
             - {in_data.elem_b[MAG_W-1], in_data.elem_b};
    d_mag_in = diff[MAG_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];
    a_mag_in = in_data.elem_a[MAG_W-1] ? MAG_W'(-in_data.elem_a) : in_data.elem_a;
    b_mag_in = in_data.elem_b[MAG_W-1] ? MAG_W'(-in_data.elem_b) : in_data.elem_b;
  end

  assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

  // Square-root step.
  always_comb begin
    sq_rem_sh   = {sq_rem_r, sq_val_r[63:62]};
    sq_trial    = {2'b0, sq_root_r, 2'b01};
    sq_ge       = sq_rem_sh >= sq_trial;
    sq_diff     = sq_rem_sh - sq_trial;
    sq_rem_nxt  = sq_ge ? sq_diff[33:0] : sq_rem_sh[33:0];
    sq_root_nxt = {sq_root_r[30:0], sq_ge};
  end

  // Divide step and final scaling of the cosine.
  always_comb begin
    dot_mag    = dot_acc_r[ACC_WIDTH-1] ? ACC_WIDTH'(-dot_acc_r) : dot_acc_r;
    dv_den     = {1'b0, prod_r[61:0]};
    dv_num_chk = {2'b0, dot_mag, 13'b0};
    dv_rsh     = {dv_rem_r, 1'b0};
    dv_ge      = dv_rsh >= dv_den;
    dv_sub     = dv_rsh - dv_den;
    dv_rem_nxt = dv_ge ? dv_sub[61:0] : dv_rsh[61:0];
    dv_q_nxt   = {dv_q_r[DIV_STEPS-2:0], dv_ge};
    cos_q      = (dv_q_nxt > DIV_STEPS'(COS_ONE)) ? DIST_WIDTH'(COS_ONE)
                                                  : DIST_WIDTH'(dv_q_nxt);
    cos_signed = dot_acc_r[ACC_WIDTH-1] ? -cos_q : cos_q;
  end

  // Dot product accumulate with saturation at the signed 48-bit limits.
  always_comb begin
    pm_ext  = {{(ACC_WIDTH+1-32){1'b0}}, prod_r[31:0]};
    dot_sum = {dot_acc_r[ACC_WIDTH-1], dot_acc_r} + (neg_r ? -pm_ext : pm_ext);
    if (dot_sum[ACC_WIDTH] != dot_sum[ACC_WIDTH-1]) begin
      dot_nxt = dot_sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                   : {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end else begin
      dot_nxt = dot_sum[ACC_WIDTH-1:0];
    end
  end

  assign sq_done   = (cnt_r == CNT_W'(SQRT_STEPS - 1));
  assign dv_done   = (cnt_r == CNT_W'(DIV_STEPS - 1));
  assign norm_zero = (na_acc_r == '0) || (nb_acc_r == '0);

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_MUL_DD;
      ST_MUL_DD:  state_nxt = ST_MUL_AA;
      ST_MUL_AA:  state_nxt = ST_MUL_BB;
      ST_MUL_BB:  state_nxt = ST_MUL_AB;
      ST_MUL_AB:  state_nxt = ST_ACC_AB;
      ST_ACC_AB:  state_nxt = last_r ? ST_START : ST_IDLE;
      ST_START: begin
        if (!mode_r) state_nxt = ST_SQRT_E;
        else if (norm_zero) state_nxt = ST_FIN;
        else state_nxt = ST_SQRT_A;
      end
      ST_SQRT_E:  if (sq_done) state_nxt = ST_FIN;
      ST_SQRT_A:  if (sq_done) state_nxt = ST_SQRT_B;
      ST_SQRT_B:  if (sq_done) state_nxt = ST_MUL_D;
      ST_MUL_D:   state_nxt = ST_DIV_CHK;
      ST_DIV_CHK: state_nxt = (dv_num_chk >= dv_den) ? ST_FIN : ST_DIV;
      ST_DIV:     if (dv_done) state_nxt = ST_FIN;
      ST_FIN:     if (fin_load) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Output logic of the sequencer: handshake and multiplier operand select.
  // The root product stays on the multiplier through the range check and the
  // divide, so prod_r keeps the divisor for all of those cycles.
  always_comb begin
    in_ready = 1'b0;
    fin_load = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_MUL_DD: begin
        mul_a = 32'(d_mag_r);
        mul_b = 32'(d_mag_r);
      end
      ST_MUL_AA: begin
        mul_a = 32'(a_mag_r);
        mul_b = 32'(a_mag_r);
      end
      ST_MUL_BB: begin
        mul_a = 32'(b_mag_r);
        mul_b = 32'(b_mag_r);
      end
      ST_MUL_AB: begin
        mul_a = 32'(a_mag_r);
        mul_b = 32'(b_mag_r);
      end
      ST_MUL_D, ST_DIV_CHK, ST_DIV: begin
        mul_a = ra_r;
        mul_b = rb_r;
      end
      ST_FIN:    fin_load = !out_valid_r || out_ready;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Control registers and accumulators.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
      sq_acc_r    <= '0;
      na_acc_r    <= '0;
      nb_acc_r    <= '0;
      dot_acc_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) mode_r <= cfg_wdata;
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_MUL_AA: sq_acc_r  <= sat_uadd(sq_acc_r, prod_r[ACC_WIDTH-1:0]);
        ST_MUL_BB: na_acc_r  <= sat_uadd(na_acc_r, prod_r[ACC_WIDTH-1:0]);
        ST_MUL_AB: nb_acc_r  <= sat_uadd(nb_acc_r, prod_r[ACC_WIDTH-1:0]);
        ST_ACC_AB: dot_acc_r <= dot_nxt;
        ST_FIN: begin
          if (fin_load) begin
            sq_acc_r  <= '0;
            na_acc_r  <= '0;
            nb_acc_r  <= '0;
            dot_acc_r <= '0;
          end
        end
        default: begin
          sq_acc_r <= sq_acc_r;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (fin_load) out_data_r <= '{distance: res_r, zero_norm: res_zf_r};
    case (state_r)
      ST_IDLE: begin
        a_mag_r <= a_mag_in;
        b_mag_r <= b_mag_in;
        d_mag_r <= d_mag_in;
        neg_r   <= in_data.elem_a[MAG_W-1] ^ in_data.elem_b[MAG_W-1];
        last_r  <= in_data.last_elem;
      end
      ST_START: begin
        sq_root_r <= '0;
        sq_rem_r  <= '0;
        cnt_r     <= '0;
        res_r     <= '0;
        res_zf_r  <= mode_r;
        sq_val_r  <= mode_r ? (64'(na_acc_r) << COS_SHIFT) : (64'(sq_acc_r) << EUC_SHIFT);
      end
      ST_SQRT_E, ST_SQRT_A, ST_SQRT_B: begin
        sq_val_r  <= {sq_val_r[61:0], 2'b00};
        sq_rem_r  <= sq_rem_nxt;
        sq_root_r <= sq_root_nxt;
        cnt_r     <= cnt_r + CNT_W'(1);
        if (sq_done) begin
          sq_root_r <= '0;
          sq_rem_r  <= '0;
          sq_val_r  <= 64'(nb_acc_r) << COS_SHIFT;
          if (state_r == ST_SQRT_E) begin
            res_r    <= sq_root_nxt;
            res_zf_r <= 1'b0;
          end
          if (state_r == ST_SQRT_A) ra_r <= sq_root_nxt;
          if (state_r == ST_SQRT_B) rb_r <= sq_root_nxt;
        end
      end
      ST_DIV_CHK: begin
        res_zf_r <= 1'b0;
        cnt_r    <= '0;
        dv_q_r   <= '0;
        dv_rem_r <= dv_num_chk[61:0];
        res_r    <= dot_acc_r[ACC_WIDTH-1] ? -DIST_WIDTH'(COS_ONE) : DIST_WIDTH'(COS_ONE);
      end
      ST_DIV: begin
        dv_rem_r <= dv_rem_nxt;
        dv_q_r   <= dv_q_nxt;
        cnt_r    <= cnt_r + CNT_W'(1);
        if (dv_done) res_r <= cos_signed;
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The sequencer is busy on the cycle after every input transfer.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on back-to-back cycles");

  // A zero-norm result always carries a zero distance.
  a_zero_norm_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_norm |-> out_data.distance == '0)
    else $error("zero_norm result with nonzero distance");

  // Results stay within the cosine floor and the Euclidean root range.
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.distance >= -32'sd65536) && (out_data.distance < 32'sh1000_0000))
    else $error("result outside reachable range");

endmodule
`default_nettype wire

// ===== test/vdc_checker.sv =====
// Checker for the vector distance / cosine block: predicts each result and compares it.
`timescale 1ns / 100ps
module vdc_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  vdc_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  vdc_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  output int                 mismatch_count,
  output int                 pending_results,
  output int                 results_checked
);
  import vdc_pkg::*;

  localparam longint unsigned ACC_MAX = (64'd1 << ACC_WIDTH) - 64'd1;
  localparam longint DOT_MAX = (64'sd1 <<< (ACC_WIDTH - 1)) - 64'sd1;
  localparam longint DOT_MIN = -DOT_MAX - 64'sd1;
  localparam longint unsigned DIST_MAX = 64'h7FFF_FFFF;
  localparam logic COSINE_MODE = 1'b1;

  // Running sums of the vector pair in flight.
  longint unsigned sq_diff_sum;
  longint unsigned norm_a_sum;
  longint unsigned norm_b_sum;
  longint          dot_sum;
  logic            metric_mode;

  out_item_t expected_metrics[$];
  out_item_t want;

  initial begin
    mismatch_count  = 0;
    results_checked = 0;
    pending_results = 0;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root, one_bit;
    root    = 0;
    one_bit = 64'h4000_0000_0000_0000;
    while (one_bit > v) one_bit = one_bit >> 2;
    while (one_bit != 0) begin
      if (v >= root + one_bit) begin
        v    = v - (root + one_bit);
        root = (root >> 1) + one_bit;
      end else begin
        root = root >> 1;
      end
      one_bit = one_bit >> 2;
    end
    return root;
  endfunction

  function automatic longint unsigned sat_acc(input longint unsigned acc,
                                              input longint unsigned term);
    if (term > ACC_MAX || acc + term > ACC_MAX) return ACC_MAX;
    return acc + term;
  endfunction

  // Cosine as |dot| * 2^30 / (ra * rb), rounded down, capped at one, then signed.
  function automatic logic [31:0] cosine_ratio();
    longint unsigned ra, rb, den, num, quo, rem;
    int i;
    ra  = int_sqrt(norm_a_sum << COS_SHIFT);
    rb  = int_sqrt(norm_b_sum << COS_SHIFT);
    den = ra * rb;
    num = (dot_sum < 0) ? -dot_sum : dot_sum;
    quo = 0;
    if (den != 0) begin
      quo = num / den;
      rem = num % den;
      if (quo > 1) quo = 2;
      for (i = 0; i < 2 * COS_SHIFT + 2; i++) begin
        rem = rem << 1;
        quo = quo << 1;
        if (rem >= den) begin
          rem = rem - den;
          quo = quo | 64'd1;
        end
      end
    end
    if (quo > COS_ONE) quo = COS_ONE;
    if (dot_sum < 0) quo = -quo;
    return quo[31:0];
  endfunction

  function automatic out_item_t vector_result();
    out_item_t res;
    longint unsigned root;
    res = '0;
    if (metric_mode != COSINE_MODE) begin
      root = int_sqrt(sq_diff_sum << EUC_SHIFT);
      if (root > DIST_MAX) root = DIST_MAX;
      res.distance = root[31:0];
    end else if (norm_a_sum == 0 || norm_b_sum == 0) begin
      res.zero_norm = 1'b1;
    end else begin
      res.distance = cosine_ratio();
    end
    return res;
  endfunction

  task automatic accumulate_pair(input in_item_t pair);
    longint a, b, diff, dot_next;
    longint unsigned dmag, amag, bmag;
    a    = longint'($signed(pair.elem_a));
    b    = longint'($signed(pair.elem_b));
    diff = a - b;
    dmag = (diff < 0) ? -diff : diff;
    amag = (a < 0) ? -a : a;
    bmag = (b < 0) ? -b : b;
    sq_diff_sum = sat_acc(sq_diff_sum, dmag * dmag);
    norm_a_sum  = sat_acc(norm_a_sum, amag * amag);
    norm_b_sum  = sat_acc(norm_b_sum, bmag * bmag);
    dot_next = dot_sum + a * b;
    if (dot_next > DOT_MAX) dot_next = DOT_MAX;
    if (dot_next < DOT_MIN) dot_next = DOT_MIN;
    dot_sum = dot_next;
    if (pair.last_elem) begin
      expected_metrics.insert(expected_metrics.size(), vector_result());
      sq_diff_sum = 0;
      norm_a_sum  = 0;
      norm_b_sum  = 0;
      dot_sum     = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint exp_val);
    mismatch_count++;
    $display("[%0t] result %0d: %s is %0d, predicted %0d",
             $time, results_checked, what, got, exp_val);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sq_diff_sum = 0;
      norm_a_sum  = 0;
      norm_b_sum  = 0;
      dot_sum     = 0;
      metric_mode = 1'b0;
      expected_metrics.delete();
    end else begin
      if (cfg_we) metric_mode = cfg_wdata;
      if (in_valid && in_ready) accumulate_pair(in_data);
      if (out_valid && out_ready) begin
        if (expected_metrics.size() == 0) begin
          report_mismatch("unexpected result, distance", out_data.distance, 0);
        end else begin
          want = expected_metrics.pop_front();
          if (out_data.distance !== want.distance)
            report_mismatch("distance", out_data.distance, want.distance);
          if (out_data.zero_norm !== want.zero_norm)
            report_mismatch("zero_norm", out_data.zero_norm, want.zero_norm);
          results_checked++;
        end
      end
    end
    pending_results <= expected_metrics.size();
  end

endmodule

// ===== test/tb_top.sv =====
// Top of the vector distance / cosine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
  import vdc_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 6;
  // This pause outlasts the slowest finish, a cosine result after its last pair,
  // so it covers any work still going on inside the block.
  localparam int QUIET_CYCLES   = 120;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PAIRS   = 440;
  localparam int PHASE_COUNT    = 8;
  // A vector of the largest difference, longer than the nominal maximum length
  // of 128.
  localparam int LONG_PAIRS     = 140;

  localparam logic MODE_EUCLID = 1'b0;
  localparam logic MODE_COSINE = 1'b1;

  localparam logic signed [ELEM_WIDTH-1:0] Q_MAX = 16'sh7FFF;
  localparam logic signed [ELEM_WIDTH-1:0] Q_MIN = 16'sh8000;
  localparam logic signed [ELEM_WIDTH-1:0] Q_ONE = 16'sd4096;

  // How the elements of one random vector pair are chosen.
  typedef enum int {
    FILL_RANDOM,
    FILL_EXTREME,
    FILL_EQUAL,
    FILL_NEGATED,
    FILL_ZERO_A,
    FILL_ZERO_B,
    FILL_MODERATE
  } fill_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_we;
  logic      cfg_wdata;

  int mismatch_count;
  int pending_results;
  int results_checked;
  int pairs_sent;
  int vectors_sent;
  int quiet_cycles;
  int sender_idle_pct;
  int recv_stall_pct;

  vector_distance_or_cosine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // The checker watches both channels and the mode writes, keeps its own
  // prediction and reports how many results are still owed.
  vdc_checker scoreboard (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Every input starts at a known value before the first edge.
  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    out_ready       = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    pairs_sent      = 0;
    vectors_sent    = 0;
    quiet_cycles    = 0;
  end

  // The receiver stalls at random with the chance of the current phase. With a
  // zero chance it is always ready, which gives the stretches without stalls.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // The watchdog restarts on every transfer on either channel. A block that stops
  // taking pairs or stops handing out results ends the run here.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results still owed",
               WATCHDOG_LIMIT, pending_results);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one element pair and returns at the edge where it is transferred.
  // The caller must drive in_valid again in the same step, either with the next
  // pair or low, so the accepted pair is never offered twice.
  task automatic send_pair(input logic signed [ELEM_WIDTH-1:0] a,
                           input logic signed [ELEM_WIDTH-1:0] b,
                           input logic last);
    in_item_t pair;
    pair.elem_a    = a;
    pair.elem_b    = b;
    pair.last_elem = last;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pair;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pairs_sent++;
    if (last) vectors_sent++;
  endtask

  // The mode is only changed with the block idle: all owed results have come out
  // and the sequencer has had time to finish whatever it was still doing.
  task automatic set_metric_mode(input logic mode);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic signed [ELEM_WIDTH-1:0] pick_elem(input fill_t fill);
    case (fill)
      FILL_EXTREME: begin
        case ($urandom_range(6))
          0: return Q_MIN;
          1: return Q_MIN + 16'sd1;
          2: return -16'sd1;
          3: return 16'sd0;
          4: return 16'sd1;
          5: return Q_MAX - 16'sd1;
          default: return Q_MAX;
        endcase
      end
      // Typical normalized features, within about two units of Q3.12.
      FILL_MODERATE: return 16'(int'($urandom_range(16384)) - 8192);
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly short vectors so that results come often; now and then a long one of
  // up to 140, which can pass the nominal maximum length of 128.
  function automatic int pick_length();
    if ($urandom_range(39) == 0) return $urandom_range(100, 140);
    return $urandom_range(1, 8);
  endfunction

  function automatic fill_t pick_fill();
    int r;
    r = $urandom_range(9);
    if (r >= FILL_MODERATE) return FILL_MODERATE;
    return fill_t'(r);
  endfunction

  // Sends one vector pair; the final element carries last_elem.
  task automatic send_vector(input int len, input fill_t fill);
    logic signed [ELEM_WIDTH-1:0] a, b;
    int i;
    for (i = 0; i < len; i++) begin
      a = pick_elem(fill);
      case (fill)
        FILL_EQUAL:   b = a;
        FILL_NEGATED: b = -a;
        FILL_ZERO_A: begin
          b = a;
          a = '0;
        end
        FILL_ZERO_B:  b = '0;
        default:      b = pick_elem(fill);
      endcase
      send_pair(a, b, i == len - 1);
    end
  endtask

  initial begin : stimulus
    int k;
    int i;
    int phase_start;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Euclidean distance: the largest single difference in both directions,
    // identical vectors, and the smallest nonzero difference.
    set_metric_mode(MODE_EUCLID);
    send_pair(Q_MAX, Q_MIN, 1'b1);
    send_pair(Q_MIN, Q_MAX, 1'b1);
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(Q_ONE, Q_ONE, 1'b0);
    send_pair(-Q_ONE, -Q_ONE, 1'b1);
    send_pair(16'sd1, 16'sd0, 1'b1);

    // Cosine similarity: parallel and opposite vectors hit the clamp at one,
    // a zero norm on either side or both gives the flag, orthogonal vectors
    // give zero without the flag.
    set_metric_mode(MODE_COSINE);
    send_pair(Q_ONE, Q_ONE, 1'b1);
    send_pair(Q_ONE, -Q_ONE, 1'b1);
    send_pair(16'sd0, Q_ONE, 1'b1);
    send_pair(Q_ONE, 16'sd0, 1'b1);
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(Q_MIN, Q_MIN, 1'b0);
    send_pair(Q_MAX, Q_MAX, 1'b0);
    send_pair(16'sd1, -16'sd1, 1'b1);
    send_pair(Q_ONE, 16'sd0, 1'b0);
    send_pair(16'sd0, Q_ONE, 1'b1);
    send_pair(Q_MIN, Q_MAX, 1'b1);
    send_pair(16'sd1, 16'sd1, 1'b1);
    send_pair(-16'sd1, Q_MIN, 1'b1);

    // One long Euclidean vector of the largest difference, past the nominal
    // maximum length.
    set_metric_mode(MODE_EUCLID);
    for (i = 0; i < LONG_PAIRS; i++) begin
      send_pair(Q_MAX, Q_MIN, i == LONG_PAIRS - 1);
    end

    // Random vectors. Each idling mix runs once per metric mode; every phase
    // ends on a complete vector so that the mode write finds the block idle.
    for (k = 0; k < PHASE_COUNT; k++) begin
      set_metric_mode((k % 2 == 1) ? MODE_COSINE : MODE_EUCLID);
      case (k / 2)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
        end
        1: begin
          sender_idle_pct = 71;
          recv_stall_pct  = 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 71;
        end
        default: begin
          sender_idle_pct = 16;
          recv_stall_pct  = 16;
        end
      endcase
      phase_start = pairs_sent;
      while (pairs_sent - phase_start < RANDOM_PAIRS / PHASE_COUNT) begin
        send_vector(pick_length(), pick_fill());
      end
    end

    // Drain: wait for every owed result, then give the block time to show any
    // result that nobody asked for.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);

    $display("covered: %0d element pairs in %0d vectors, %0d results compared",
             pairs_sent, vectors_sent, results_checked);
    $display("covered: both metrics, zero norms, overlong vectors, four idle/stall mixes");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
